/* hw/rtl/swe_pkg.sv */
// swe_pkg: shared types and constants for the sliding window envelope unit.
// No dependencies.
`timescale 1ns / 1ps
package swe_pkg;
    localparam int R_MAX       = 63;
    localparam int DEQUE_DEPTH = 128;
    localparam int SAMPLE_BITS = 16;
    localparam int COUNT_BITS  = 16;
    localparam int PTR_BITS    = $clog2(DEQUE_DEPTH);
    localparam int LEN_BITS    = $clog2(DEQUE_DEPTH + 1);
    localparam int RAD_BITS    = 6;
    localparam int SEEN_BITS   = 8;
    localparam int ENTRY_BITS  = COUNT_BITS + SAMPLE_BITS;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          last;
    } swe_in_t;

    typedef struct packed {
        logic [COUNT_BITS-1:0]         position;
        logic signed [SAMPLE_BITS-1:0] upper;
        logic signed [SAMPLE_BITS-1:0] lower;
        logic                          end_of_run;
    } swe_out_t;

    // one deque entry: index and sample
    typedef struct packed {
        logic [COUNT_BITS-1:0]         idx;
        logic signed [SAMPLE_BITS-1:0] val;
    } swe_entry_t;

    // deque status toward the sequencer
    typedef struct packed {
        logic                          busy;
        logic signed [SAMPLE_BITS-1:0] front_val;
    } swe_dq_stat_t;

    // command from sequencer to both deques
    typedef struct packed {
        logic                          push;
        logic                          expire;
        logic                          clear;
        logic [COUNT_BITS-1:0]         now;
        logic [COUNT_BITS:0]           keep;
        logic signed [SAMPLE_BITS-1:0] x;
    } swe_dq_cmd_t;
endpackage

/* hw/rtl/swe_ram.sv */
// swe_ram: generic single-port-write, single-port-read RAM, registered read.
// No dependencies.
`timescale 1ns / 1ps
module swe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

/* hw/rtl/swe_deque.sv */
// swe_deque: monotone candidate deque kept in one RAM (max or min flavor).
// Depends on swe_pkg, swe_ram.
`timescale 1ns / 1ps
module swe_deque (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 is_max,
    input  swe_pkg::swe_dq_cmd_t cmd,
    output swe_pkg::swe_dq_stat_t stat
);
    import swe_pkg::*;

    // back and front entries are cached in registers; the RAM holds the body.
    // Pops from the back walk one entry at a time: a RAM read, then a reload of the back register.
    typedef enum logic [2:0] {S_IDLE, S_POPB, S_WAITB, S_POPF, S_WAITF} st_t;

    st_t                  st_reg;
    logic [PTR_BITS-1:0]  head_reg;
    logic [LEN_BITS-1:0]  len_reg;
    swe_entry_t           back_reg, front_reg;
    logic [COUNT_BITS-1:0] now_reg;
    logic [COUNT_BITS:0]  keep_reg;
    logic signed [SAMPLE_BITS-1:0] x_reg;

    logic                 we;
    logic [PTR_BITS-1:0]  waddr, raddr;
    swe_entry_t           wdata, rdata;
    logic                 drop;
    logic [COUNT_BITS-1:0] age;
    logic [PTR_BITS-1:0]  tail_ptr;

    swe_ram #(.WIDTH(ENTRY_BITS), .DEPTH(DEQUE_DEPTH)) u_ram (
        .aclk(aclk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    assign tail_ptr = head_reg + PTR_BITS'(len_reg - LEN_BITS'(1));
    assign drop = is_max ? (back_reg.val <= x_reg) : (back_reg.val >= x_reg);
    assign age  = now_reg - front_reg.idx;

    always_comb begin
        we    = 1'b0;
        waddr = head_reg + PTR_BITS'(len_reg);
        wdata = '{idx: now_reg, val: x_reg};
        raddr = tail_ptr - PTR_BITS'(1);
        case (st_reg)
            S_POPB: begin
                if (!(len_reg != '0 && drop)) begin
                    we = 1'b1;
                    // full deque: fetch the entry that becomes the front
                    if (len_reg == LEN_BITS'(DEQUE_DEPTH)) begin
                        raddr = head_reg + PTR_BITS'(1);
                    end
                end
            end
            S_POPF:  raddr = head_reg + PTR_BITS'(1);
            default: ;
        endcase
    end

    assign stat.busy      = (st_reg != S_IDLE);
    assign stat.front_val = front_reg.val;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg   <= S_IDLE;
            head_reg <= '0;
            len_reg  <= '0;
        end else begin
            case (st_reg)
                S_IDLE: begin
                    if (cmd.clear) begin
                        head_reg <= '0;
                        len_reg  <= '0;
                    end else if (cmd.push) begin
                        now_reg  <= cmd.now;
                        x_reg    <= cmd.x;
                        keep_reg <= cmd.keep;
                        st_reg   <= S_POPB;
                    end else if (cmd.expire) begin
                        now_reg  <= cmd.now;
                        keep_reg <= cmd.keep;
                        st_reg   <= S_POPF;
                    end
                end
                S_POPB: begin
                    if (len_reg != '0 && drop) begin
                        len_reg <= len_reg - LEN_BITS'(1);
                        st_reg  <= S_WAITB;
                    end else begin
                        // push; full deque drops its oldest entry
                        if (len_reg == LEN_BITS'(DEQUE_DEPTH)) begin
                            head_reg <= head_reg + PTR_BITS'(1);
                            st_reg   <= S_WAITF;
                        end else begin
                            len_reg <= len_reg + LEN_BITS'(1);
                            st_reg  <= S_POPF;
                        end
                        if (len_reg == '0) begin
                            front_reg <= '{idx: now_reg, val: x_reg};
                        end
                        back_reg <= '{idx: now_reg, val: x_reg};
                    end
                end
                S_WAITB: begin
                    back_reg <= rdata;
                    st_reg   <= S_POPB;
                end
                S_POPF: begin
                    if (len_reg > LEN_BITS'(1) && {1'b0, age} > keep_reg) begin
                        head_reg <= head_reg + PTR_BITS'(1);
                        len_reg  <= len_reg - LEN_BITS'(1);
                        st_reg   <= S_WAITF;
                    end else begin
                        st_reg <= S_IDLE;
                    end
                end
                S_WAITF: begin
                    front_reg <= rdata;
                    st_reg    <= S_POPF;
                end
                default: st_reg <= S_IDLE;
            endcase
        end
    end

    // a RAM write only in the push step, never with the deque full beyond depth
    property p_len_bound;
        @(posedge aclk) disable iff (!aresetn) len_reg <= LEN_BITS'(DEQUE_DEPTH);
    endproperty
    a_len_bound: assert property (p_len_bound) else $error("deque overfull");

    property p_push_grows;
        @(posedge aclk) disable iff (!aresetn)
            (st_reg == S_POPB && we && len_reg != LEN_BITS'(DEQUE_DEPTH))
            |=> len_reg == $past(len_reg) + LEN_BITS'(1);
    endproperty
    a_push_grows: assert property (p_push_grows) else $error("push lost");

    property p_clear_idle;
        @(posedge aclk) disable iff (!aresetn)
            (st_reg == S_IDLE && cmd.clear) |=> len_reg == '0;
    endproperty
    a_clear_idle: assert property (p_clear_idle) else $error("clear failed");
endmodule

/* hw/rtl/sliding_window_envelope_unit.sv */
// sliding_window_envelope_unit: streaming min/max envelope over radius r.
// Depends on swe_pkg, swe_deque (which uses swe_ram).
`timescale 1ns / 1ps
//  channel | ports                          | content
//  --------+--------------------------------+-------------------------------
//  input   | s_valid s_ready s_data         | sample, last
//  result  | m_valid m_ready m_data         | position, upper, lower, end_of_run
//  config  | cfg_we cfg_wdata               | window_radius (6 bit, sat R_MAX)
//
// A sample is taken only in idle and is pushed and expired in both deques; each
// pop is one RAM read plus a reload, and the result waits in S_OUT for m_ready.
// A final sample flushes up to r more results, each after an expire of the front
// entries, then the series is cleared after the last transfer.
// Reset clears all control state; candidate RAM contents need no clearing.
// A stalled result holds in m_data; the sequencer waits, no item is lost.
module sliding_window_envelope_unit (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_we,
    input  logic [5:0]       cfg_wdata,
    input  logic             s_valid,
    output logic             s_ready,
    input  swe_pkg::swe_in_t s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output swe_pkg::swe_out_t m_data
);
    import swe_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_INS, S_EMIT, S_FEXP, S_FEMIT, S_OUT
    } st_t;

    st_t                    st_reg, ret_reg;
    logic [RAD_BITS-1:0]    rad_reg;
    logic [COUNT_BITS-1:0]  cnt_reg;
    logic [SEEN_BITS-1:0]   seen_reg;
    logic [RAD_BITS-1:0]    m_reg;
    logic                   last_reg;
    logic signed [SAMPLE_BITS-1:0] x_reg;
    logic                   mval_reg;
    swe_out_t               mdat_reg;
    logic                   go_reg;   // one-cycle command strobe

    swe_dq_cmd_t  cmd;
    swe_dq_stat_t st_max, st_min;
    logic         dq_busy;
    logic [SEEN_BITS-1:0] seen_inc;

    assign dq_busy = st_max.busy | st_min.busy;
    assign s_ready = (st_reg == S_IDLE);
    assign m_valid = mval_reg;
    assign m_data  = mdat_reg;

    always_comb begin
        cmd        = '0;
        cmd.now    = cnt_reg;
        cmd.x      = x_reg;
        cmd.keep   = {1'b0, COUNT_BITS'({rad_reg, 1'b0})};
        if (go_reg) begin
            case (st_reg)
                S_INS: begin
                    cmd.push   = 1'b1;
                    cmd.expire = 1'b1;
                end
                S_FEXP: begin
                    cmd.expire = 1'b1;
                    cmd.keep   = {1'b0, COUNT_BITS'(m_reg) + COUNT_BITS'(rad_reg)};
                end
                default: ;
            endcase
        end
        if (st_reg == S_OUT && !mval_reg && ret_reg == S_IDLE && last_reg) begin
            cmd.clear = 1'b1;
        end
    end

    swe_deque u_max (.aclk(aclk), .aresetn(aresetn), .is_max(1'b1), .cmd(cmd), .stat(st_max));
    swe_deque u_min (.aclk(aclk), .aresetn(aresetn), .is_max(1'b0), .cmd(cmd), .stat(st_min));

    assign seen_inc = (seen_reg == '1) ? seen_reg : seen_reg + SEEN_BITS'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg   <= S_IDLE;
            ret_reg  <= S_IDLE;
            rad_reg  <= '0;
            cnt_reg  <= '0;
            seen_reg <= '0;
            mval_reg <= 1'b0;
            go_reg   <= 1'b0;
        end else begin
            go_reg <= 1'b0;
            if (cfg_we) begin
                rad_reg <= (cfg_wdata > 6'(R_MAX)) ? RAD_BITS'(R_MAX) : cfg_wdata;
            end
            if (m_valid && m_ready) begin
                mval_reg <= 1'b0;
            end
            case (st_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        x_reg    <= s_data.sample;
                        last_reg <= s_data.last;
                        seen_reg <= seen_inc;
                        go_reg   <= 1'b1;
                        st_reg   <= S_INS;
                    end
                end
                S_INS: begin
                    if (!go_reg && !dq_busy) begin
                        st_reg <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    // emitted after insert and expire by 2r
                    if (seen_reg >= SEEN_BITS'(rad_reg) + SEEN_BITS'(1)) begin
                        mdat_reg <= '{position: cnt_reg - COUNT_BITS'(rad_reg),
                                      upper: st_max.front_val, lower: st_min.front_val,
                                      end_of_run: last_reg && rad_reg == '0};
                        mval_reg <= 1'b1;
                        st_reg   <= S_OUT;
                    end else begin
                        st_reg <= S_OUT;
                    end
                    if (last_reg && rad_reg != '0) begin
                        ret_reg <= S_FEXP;
                        m_reg   <= (seen_reg - SEEN_BITS'(1) >
                                    SEEN_BITS'(rad_reg - RAD_BITS'(1)))
                                   ? rad_reg - RAD_BITS'(1)
                                   : RAD_BITS'(seen_reg - SEEN_BITS'(1));
                    end else begin
                        ret_reg <= S_IDLE;
                    end
                end
                S_FEXP: begin
                    if (!go_reg && !dq_busy) begin
                        st_reg <= S_FEMIT;
                    end
                end
                S_FEMIT: begin
                    mdat_reg <= '{position: cnt_reg - COUNT_BITS'(m_reg),
                                  upper: st_max.front_val, lower: st_min.front_val,
                                  end_of_run: m_reg == '0};
                    mval_reg <= 1'b1;
                    st_reg   <= S_OUT;
                    if (m_reg == '0) begin
                        ret_reg <= S_IDLE;
                    end else begin
                        ret_reg <= S_FEXP;
                    end
                end
                S_OUT: begin
                    // wait until the result register is free
                    if (!mval_reg || (m_valid && m_ready)) begin
                        if (ret_reg == S_FEXP) begin
                            if (st_reg == S_OUT && mval_reg && mdat_reg.end_of_run) begin
                                st_reg <= S_IDLE;
                            end else begin
                                if (mval_reg && !last_reg) begin
                                    st_reg <= S_IDLE;
                                end else begin
                                    if (m_reg != '0 && mval_reg &&
                                        mdat_reg.position == cnt_reg - COUNT_BITS'(m_reg)) begin
                                        m_reg <= m_reg - RAD_BITS'(1);
                                    end
                                    go_reg <= 1'b1;
                                    st_reg <= S_FEXP;
                                end
                            end
                        end else if (mval_reg || !mval_reg) begin
                            if (!mval_reg || (m_valid && m_ready)) begin
                                if (last_reg) begin
                                    if (!mval_reg) begin
                                        cnt_reg  <= '0;
                                        seen_reg <= '0;
                                        st_reg   <= S_IDLE;
                                    end
                                end else begin
                                    cnt_reg <= cnt_reg + COUNT_BITS'(1);
                                    st_reg  <= S_IDLE;
                                end
                            end
                        end
                    end
                end
                default: st_reg <= S_IDLE;
            endcase
        end
    end

    property p_out_hold;
        @(posedge aclk) disable iff (!aresetn)
            (m_valid && !m_ready) |=> m_valid && $stable(m_data);
    endproperty
    a_out_hold: assert property (p_out_hold) else $error("result dropped");

    property p_no_accept_busy;
        @(posedge aclk) disable iff (!aresetn) s_ready |-> !dq_busy;
    endproperty
    a_no_accept_busy: assert property (p_no_accept_busy) else $error("accept while busy");

    property p_rad_bound;
        @(posedge aclk) disable iff (!aresetn) rad_reg <= RAD_BITS'(R_MAX);
    endproperty
    a_rad_bound: assert property (p_rad_bound) else $error("radius out of range");
endmodule
